// ===== rtl/ltd_pkg.sv =====
// Shared types and constants for the LZ77 triple decoder.
// Depends on nothing; imported by every module of the block.
package ltd_pkg;

    localparam int OFF_W  = 12;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;
    localparam logic [CNT_W-1:0]  CAPACITY_RESET    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] lit;
        logic              first;
    } ltd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ltd_qstat_t;

endpackage

// ===== rtl/ltd_queue.sv =====
// Two-entry command queue between the front and back parts of the decoder.
// Depends on ltd_pkg for the command and status types.
module ltd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ltd_pkg::ltd_cmd_t push_cmd,
    input  logic              pop,
    output ltd_pkg::ltd_cmd_t head,
    output ltd_pkg::ltd_qstat_t stat
);
    import ltd_pkg::*;

    ltd_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/ltd_front.sv =====
// Front part: accepts input triples, folds the offset into the window and
// saturates the length, then pushes a command into the queue. Uses ltd_pkg.
module ltd_front #(
    parameter int WINDOW_SIZE = 4096,
    parameter int MAX_LENGTH  = 63
) (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ltd_pkg::OFF_W-1:0]   back_offset,
    input  logic [ltd_pkg::LEN_W-1:0]   copy_length,
    input  logic [ltd_pkg::BYTE_W-1:0]  literal_byte,
    input  logic                        first_of_stream,
    input  ltd_pkg::ltd_qstat_t         stat,
    output logic                        push,
    output ltd_pkg::ltd_cmd_t           push_cmd
);
    import ltd_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LENGTH);

    function automatic logic [OFF_W-1:0] fold_offset(input logic [OFF_W-1:0] off);
        logic [19:0] r;
        r = 20'(off);
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (20'(WINDOW_SIZE) << k))
            begin
                r = r - (20'(WINDOW_SIZE) << k);
            end
        end
        return OFF_W'(r);
    endfunction

    assign in_stall = stat.full;
    assign push     = in_valid && !stat.full;

    always_comb
    begin
        push_cmd.off   = fold_offset(back_offset);
        push_cmd.len   = (copy_length > MAX_LEN) ? MAX_LEN : copy_length;
        push_cmd.lit   = literal_byte;
        push_cmd.first = first_of_stream;
    end

endmodule

// ===== rtl/ltd_back.sv =====
// Back part: checks capacity, copies history bytes and emits the literal,
// one result beat per cycle within a triple while out_stall is low, through an output register. Uses ltd_pkg.
module ltd_back #(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ltd_pkg::CNT_W-1:0]   capacity,
    input  ltd_pkg::ltd_cmd_t           head,
    input  ltd_pkg::ltd_qstat_t         stat,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ltd_pkg::BYTE_W-1:0]  data_byte,
    output logic                        last_of_run,
    output logic                        overflow,
    output logic [ltd_pkg::CNT_W-1:0]   bytes_written
);
    import ltd_pkg::*;

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_SIZE - 1);
    localparam logic [AW:0]   WIN_EXT = (AW+1)'(WINDOW_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_LIT,
        S_OVF
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     wp_reg;
    logic              wrapped_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              stopped_reg;
    logic [AW-1:0]     off_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [BYTE_W-1:0] lit_reg;
    logic              src_ok_reg;
    logic              fwd_reg;
    logic [BYTE_W-1:0] last_byte_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  written_reg;

    logic [BYTE_W-1:0] mem [WINDOW_SIZE];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              load_ok;
    logic              emit;
    logic [AW-1:0]     wp_inc;
    logic              wrap_after;
    logic [CNT_W-1:0]  base_count;
    logic              base_stop;
    logic              too_long;
    logic [AW-1:0]     iss_wp;
    logic              iss_wrap;
    logic [AW-1:0]     iss_off;
    logic [AW:0]       src_sum;
    logic [AW-1:0]     src;
    logic              src_ok;
    logic              issue;
    logic              we;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] cp_byte;

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_reg;
    assign last_of_run   = last_reg;
    assign overflow      = ovf_reg;
    assign bytes_written = written_reg;

    assign load_ok    = !out_valid_reg || !out_stall;
    assign emit       = load_ok && (state_reg != S_IDLE);
    assign pop        = (state_reg == S_IDLE) && !stat.empty;
    assign wp_inc     = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);
    assign wrap_after = wrapped_reg || (wp_reg == WP_LAST);
    assign base_count = head.first ? '0 : count_reg;
    assign base_stop  = head.first ? 1'b0 : stopped_reg;
    assign too_long   = ({1'b0, base_count} + (CNT_W+1)'(head.len) + (CNT_W+1)'(1))
                        > {1'b0, capacity};
    assign cp_byte    = fwd_reg ? last_byte_reg : (src_ok_reg ? rd_data_reg : '0);

    always_comb
    begin
        iss_wp   = (state_reg == S_IDLE) ? wp_reg : wp_inc;
        iss_wrap = (state_reg == S_IDLE) ? wrapped_reg : wrap_after;
        iss_off  = (state_reg == S_IDLE) ? AW'(head.off) : off_reg;
        src_sum  = {1'b0, iss_wp} + WIN_EXT - {1'b0, iss_off};
        src      = (src_sum >= WIN_EXT) ? AW'(src_sum - WIN_EXT) : AW'(src_sum);
        src_ok   = iss_wrap || (src < iss_wp);
        issue    = 1'b0;
        we       = 1'b0;
        wr_byte  = cp_byte;
        unique case (state_reg)
            S_IDLE:
            begin
                issue = pop && !base_stop && !too_long && (head.len != '0);
            end
            S_COPY:
            begin
                we    = load_ok;
                issue = load_ok && (rem_reg != LEN_W'(1));
            end
            S_LIT:
            begin
                we      = load_ok;
                wr_byte = lit_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wp_reg] <= wr_byte;
        end
        if (issue)
        begin
            rd_data_reg <= mem[src];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            off_reg       <= '0;
            rem_reg       <= '0;
            lit_reg       <= '0;
            src_ok_reg    <= 1'b0;
            fwd_reg       <= 1'b0;
            last_byte_reg <= '0;
            out_valid_reg <= 1'b0;
            data_reg      <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (issue)
            begin
                src_ok_reg <= src_ok;
                fwd_reg    <= (state_reg == S_COPY) && (src == wp_reg);
            end
            if (we)
            begin
                wp_reg      <= wp_inc;
                wrapped_reg <= wrap_after;
                count_reg   <= count_reg + CNT_W'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        count_reg   <= base_count;
                        stopped_reg <= base_stop || too_long;
                        off_reg     <= AW'(head.off);
                        rem_reg     <= head.len;
                        lit_reg     <= head.lit;
                        if (base_stop)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (too_long)
                        begin
                            state_reg <= S_OVF;
                        end
                        else if (head.len == '0)
                        begin
                            state_reg <= S_LIT;
                        end
                        else
                        begin
                            state_reg <= S_COPY;
                        end
                    end
                end
                S_COPY:
                begin
                    if (load_ok)
                    begin
                        last_byte_reg <= cp_byte;
                        data_reg      <= cp_byte;
                        last_reg      <= 1'b0;
                        ovf_reg       <= 1'b0;
                        written_reg   <= count_reg + CNT_W'(1);
                        rem_reg       <= rem_reg - LEN_W'(1);
                        if (rem_reg == LEN_W'(1))
                        begin
                            state_reg <= S_LIT;
                        end
                    end
                end
                S_LIT:
                begin
                    if (load_ok)
                    begin
                        data_reg    <= lit_reg;
                        last_reg    <= 1'b1;
                        ovf_reg     <= 1'b0;
                        written_reg <= count_reg + CNT_W'(1);
                        state_reg   <= S_IDLE;
                    end
                end
                S_OVF:
                begin
                    if (load_ok)
                    begin
                        data_reg    <= '0;
                        last_reg    <= 1'b1;
                        ovf_reg     <= 1'b1;
                        written_reg <= count_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/lz77_triple_decoder_top.sv =====
// Top level of the LZ77 triple decoder: capacity register, front part,
// command queue and back part. Depends on ltd_pkg, ltd_front, ltd_queue, ltd_back.
//
// Each triple (offset, length, literal) yields length copied bytes followed by
// the literal, one result beat per cycle from the back part while out_stall is
// low; the last beat of a triple is marked. In the back part a triple first
// has its capacity checked and its first history read issued, then its bytes
// are written in turn, bounded by the single read and single write port of
// the history memory; an overflow triple yields one marked beat and a triple
// dropped after overflow yields none. A two-entry queue lets new triples
// arrive while the back part works. The history window reads as zero where
// never written since reset, tracked by the write pointer and a wrap flag, so
// no clearing pass is needed after reset. output_capacity sits at byte
// address 0 of the configuration port; write it only while the block is idle.
module lz77_triple_decoder_top #(
    parameter int WINDOW_SIZE = 4096,
    parameter int MAX_LENGTH  = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ltd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ltd_pkg::OFF_W-1:0]   back_offset,
    input  logic [ltd_pkg::LEN_W-1:0]   copy_length,
    input  logic [ltd_pkg::BYTE_W-1:0]  literal_byte,
    input  logic                        first_of_stream,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ltd_pkg::BYTE_W-1:0]  data_byte,
    output logic                        last_of_run,
    output logic                        overflow,
    output logic [ltd_pkg::CNT_W-1:0]   bytes_written
);
    import ltd_pkg::*;

    logic [CNT_W-1:0] capacity_reg;
    logic             push;
    logic             pop;
    ltd_cmd_t         push_cmd;
    ltd_cmd_t         head;
    ltd_qstat_t       stat;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAPACITY_ADDR) ? capacity_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_CAPACITY_ADDR))
        begin
            capacity_reg <= pwdata;
        end
    end

    ltd_front #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .back_offset     (back_offset),
        .copy_length     (copy_length),
        .literal_byte    (literal_byte),
        .first_of_stream (first_of_stream),
        .stat            (stat),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ltd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    ltd_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity      (capacity_reg),
        .head          (head),
        .stat          (stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .last_of_run   (last_of_run),
        .overflow      (overflow),
        .bytes_written (bytes_written)
    );

endmodule
